[src/cpa_pkg.sv]
// ----------------------------------------------------------------------------
// cpa_pkg
// Shared types and constants for the contiguous page allocator.
// ----------------------------------------------------------------------------
package cpa_pkg;

   // default map depth
   localparam int NUM_PAGES_DEF = 32;

   // page size and largest request, in KB
   localparam int PAGE_KB     = 4;
   localparam int PAGE_SHIFT  = $clog2(PAGE_KB);
   localparam int MAX_KB      = 128;
   localparam int MAX_PAGES   = (MAX_KB + PAGE_KB - 1) / PAGE_KB;
   localparam int PAGES_W     = $clog2(MAX_PAGES + 1);
   localparam int SIZE_SUM_W  = 9;
   localparam int OWNER_BITS  = 8;

   typedef enum logic [1:0] {
      REQ_ALLOC = 2'd0,
      REQ_FREE  = 2'd1,
      REQ_FRAG  = 2'd2,
      REQ_READ  = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      STAT_OK       = 3'd0,
      STAT_NOSPACE  = 3'd1,
      STAT_INUSE    = 3'd2,
      STAT_NOTFOUND = 3'd3,
      STAT_INVALID  = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      SCAN_ALLOC = 2'd0,
      SCAN_FREE  = 2'd1,
      SCAN_FRAG  = 2'd2
   } scan_mode_type;

   typedef struct packed {
      logic          start;
      logic          step;
      scan_mode_type mode;
   } scan_ctrl_type;

   typedef struct packed {
      logic found;
      logic owner_hit;
   } scan_flags_type;

   typedef struct packed {
      logic [1:0] req_type;
      logic [7:0] owner_id;
      logic [7:0] size_kb;
      logic [4:0] page_index;
   } req_payload_type;

   typedef struct packed {
      logic [2:0] status;
      logic [4:0] start_page;
      logic [5:0] page_count;
      logic [4:0] fragment_count;
      logic [7:0] read_owner;
      logic       read_used;
   } rsp_payload_type;

endpackage

[src/cpa_page_store.sv]
// ----------------------------------------------------------------------------
// cpa_page_store
// Page map: used bit and owner id per page, one access address per cycle.
// ----------------------------------------------------------------------------
module cpa_page_store import cpa_pkg::*; #(
   parameter int NUM_PAGES = NUM_PAGES_DEF,
   localparam int IDX_W = $clog2(NUM_PAGES)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [IDX_W-1:0]      addr,
   output logic                  used_cur,
   output logic                  used_next,
   output logic                  is_last,
   output logic [OWNER_BITS-1:0] owner_cur,
   input  logic                  wr_en,
   input  logic                  wr_used,
   input  logic [OWNER_BITS-1:0] wr_owner
);

   logic [NUM_PAGES-1:0]  used_ff;
   logic [NUM_PAGES-1:0]  used_in;
   logic [OWNER_BITS-1:0] owner_ff [NUM_PAGES];
   logic [IDX_W-1:0]      next_addr;

   assign is_last   = (addr == IDX_W'(NUM_PAGES - 1));
   assign next_addr = is_last ? '0 : addr + 1'b1;
   assign used_cur  = used_ff[addr];
   assign used_next = is_last ? 1'b0 : used_ff[next_addr];
   assign owner_cur = owner_ff[addr];

   always_comb begin
      used_in = used_ff;
      if (wr_en) begin
         used_in[addr] = wr_used;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else begin
         used_ff <= used_in;
      end
   end

   // owner only matters while the used bit is set
   always_ff @(posedge clock) begin
      if (wr_en && wr_used) begin
         owner_ff[addr] <= wr_owner;
      end
   end

endmodule

[src/cpa_scan_unit.sv]
// ----------------------------------------------------------------------------
// cpa_scan_unit
// Per-page scan step: free-run tracking with fit choice, owner match, tallies.
// ----------------------------------------------------------------------------
module cpa_scan_unit import cpa_pkg::*; #(
   parameter int NUM_PAGES = NUM_PAGES_DEF,
   localparam int IDX_W = $clog2(NUM_PAGES),
   localparam int CNT_W = $clog2(NUM_PAGES + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  scan_ctrl_type      ctrl,
   input  logic               fit_mode,
   input  logic [PAGES_W-1:0] pages_need,
   input  logic [IDX_W-1:0]   page_ptr,
   input  logic               used_cur,
   input  logic               used_next,
   input  logic               is_last,
   input  logic               owner_match,
   output scan_flags_type     flags,
   output logic [IDX_W-1:0]   chosen_start,
   output logic [CNT_W-1:0]   chosen_length,
   output logic [CNT_W-1:0]   tally
);

   localparam int CMP_W = (CNT_W > PAGES_W) ? CNT_W : PAGES_W;

   logic [IDX_W-1:0] run_start_ff, run_start_in;
   logic [CNT_W-1:0] run_len_ff, run_len_in;
   logic [IDX_W-1:0] chosen_start_ff, chosen_start_in;
   logic [CNT_W-1:0] chosen_len_ff, chosen_len_in;
   logic [CNT_W-1:0] tally_ff, tally_in;
   scan_flags_type   flags_ff, flags_in;
   logic [CNT_W-1:0] len_new;
   logic             take;

   assign len_new = run_len_ff + 1'b1;

   always_comb begin
      if (fit_mode) begin
         take = !flags_ff.found || (len_new > chosen_len_ff);
      end else begin
         take = (CMP_W'(len_new) >= CMP_W'(pages_need)) &&
                (!flags_ff.found || (len_new < chosen_len_ff));
      end
   end

   always_comb begin
      run_start_in    = run_start_ff;
      run_len_in      = run_len_ff;
      chosen_start_in = chosen_start_ff;
      chosen_len_in   = chosen_len_ff;
      tally_in        = tally_ff;
      flags_in        = flags_ff;
      if (ctrl.start) begin
         run_start_in    = '0;
         run_len_in      = '0;
         chosen_start_in = '0;
         chosen_len_in   = '0;
         tally_in        = '0;
         flags_in        = '0;
      end else if (ctrl.step) begin
         unique case (ctrl.mode)
            SCAN_ALLOC: begin
               if (used_cur) begin
                  run_len_in = '0;
                  if (owner_match) begin
                     flags_in.owner_hit = 1'b1;
                  end
               end else begin
                  if (run_len_ff == '0) begin
                     run_start_in = page_ptr;
                  end
                  run_len_in = len_new;
                  // end of a free run
                  if ((is_last || used_next) && take) begin
                     flags_in.found  = 1'b1;
                     chosen_start_in = (run_len_ff == '0) ? page_ptr : run_start_ff;
                     chosen_len_in   = len_new;
                  end
               end
            end
            SCAN_FREE: begin
               if (owner_match) begin
                  tally_in = tally_ff + 1'b1;
               end
            end
            SCAN_FRAG: begin
               // last page of a used run
               if (used_cur && !used_next) begin
                  tally_in = tally_ff + 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_start_ff    <= '0;
         run_len_ff      <= '0;
         chosen_start_ff <= '0;
         chosen_len_ff   <= '0;
         tally_ff        <= '0;
         flags_ff        <= '0;
      end else begin
         run_start_ff    <= run_start_in;
         run_len_ff      <= run_len_in;
         chosen_start_ff <= chosen_start_in;
         chosen_len_ff   <= chosen_len_in;
         tally_ff        <= tally_in;
         flags_ff        <= flags_in;
      end
   end

   assign flags         = flags_ff;
   assign chosen_start  = chosen_start_ff;
   assign chosen_length = chosen_len_ff;
   assign tally         = tally_ff;

endmodule

[src/contiguous_page_allocator_unit.sv]
// ----------------------------------------------------------------------------
// contiguous_page_allocator_unit
// Contiguous page allocator with best-fit / worst-fit placement.
//
// One request at a time. A sequencer walks a pointer over the page map one
// page per cycle and feeds a shared scan step that tracks free runs, owner
// matches and tallies. Read passes through READ to DONE with no scan. Free
// and fragment count pass through SCAN, EVAL and DONE. Allocate passes
// through SCAN and EVAL, then, when granted, MARK sets each page of the run
// in turn before DONE. Bad size or reserved owner on allocate goes straight
// to DONE. The result sits in an output register, so a new request is taken
// while it waits.
// csr_wr_data picks the fit mode: 0 best fit, 1 worst fit; write only while
// idle.
// ----------------------------------------------------------------------------
module contiguous_page_allocator_unit import cpa_pkg::*; #(
   parameter int NUM_PAGES = NUM_PAGES_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload,
   input  logic            csr_wr_en,
   input  logic            csr_wr_data
);

   localparam int IDX_W = $clog2(NUM_PAGES);
   localparam int CNT_W = $clog2(NUM_PAGES + 1);
   localparam int CMP_W = (CNT_W > PAGES_W) ? CNT_W : PAGES_W;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_SCAN = 6'b000010,
      ST_EVAL = 6'b000100,
      ST_MARK = 6'b001000,
      ST_READ = 6'b010000,
      ST_DONE = 6'b100000
   } state_type;

   // sequencer and request registers
   state_type             state_ff, state_in;
   req_kind_type          op_ff, op_in;
   logic [OWNER_BITS-1:0] owner_ff, owner_in;
   logic [PAGES_W-1:0]    pages_ff, pages_in;
   logic [PAGES_W-1:0]    remain_ff, remain_in;
   logic [IDX_W-1:0]      ptr_ff, ptr_in;
   rsp_payload_type       res_ff, res_in;
   logic                  fit_mode_ff, fit_mode_in;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_payload_type       rsp_payload_ff, rsp_payload_in;
   logic                  rsp_load;

   // page map and scan step
   logic                  used_cur, used_next, is_last;
   logic [OWNER_BITS-1:0] owner_cur;
   logic                  owner_match;
   logic                  wr_en, wr_used;
   scan_ctrl_type         scan_ctrl;
   scan_flags_type        scan_flags;
   logic [IDX_W-1:0]      chosen_start;
   logic [CNT_W-1:0]      chosen_length;
   logic [CNT_W-1:0]      tally;

   // request decode
   logic                  req_accept;
   req_kind_type          req_kind;
   logic [PAGES_W-1:0]    size_pages;
   logic                  alloc_bad;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign req_kind   = req_kind_type'(req_payload.req_type);

   // round size up to whole pages
   assign size_pages = PAGES_W'((SIZE_SUM_W'(req_payload.size_kb) +
                                 SIZE_SUM_W'(PAGE_KB - 1)) >> PAGE_SHIFT);
   assign alloc_bad  = (req_payload.size_kb == 8'd0) || (req_payload.size_kb > MAX_KB) ||
                       (req_payload.owner_id == '0);

   assign owner_match = used_cur && (owner_cur == owner_ff);
   assign rsp_load    = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);
   assign fit_mode_in = csr_wr_en ? csr_wr_data : fit_mode_ff;

   cpa_page_store #(
      .NUM_PAGES (NUM_PAGES)
   ) u_page_store (
      .clock     (clock),
      .reset     (reset),
      .addr      (ptr_ff),
      .used_cur  (used_cur),
      .used_next (used_next),
      .is_last   (is_last),
      .owner_cur (owner_cur),
      .wr_en     (wr_en),
      .wr_used   (wr_used),
      .wr_owner  (owner_ff)
   );

   cpa_scan_unit #(
      .NUM_PAGES (NUM_PAGES)
   ) u_scan_unit (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (scan_ctrl),
      .fit_mode      (fit_mode_ff),
      .pages_need    (pages_ff),
      .page_ptr      (ptr_ff),
      .used_cur      (used_cur),
      .used_next     (used_next),
      .is_last       (is_last),
      .owner_match   (owner_match),
      .flags         (scan_flags),
      .chosen_start  (chosen_start),
      .chosen_length (chosen_length),
      .tally         (tally)
   );

   // sequencer
   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      owner_in  = owner_ff;
      pages_in  = pages_ff;
      remain_in = remain_ff;
      ptr_in    = ptr_ff;
      res_in    = res_ff;
      wr_en     = 1'b0;
      wr_used   = 1'b0;
      scan_ctrl = '{start: 1'b0, step: 1'b0, mode: SCAN_ALLOC};

      unique case (op_ff)
         REQ_FREE: scan_ctrl.mode = SCAN_FREE;
         REQ_FRAG: scan_ctrl.mode = SCAN_FRAG;
         default:  scan_ctrl.mode = SCAN_ALLOC;
      endcase

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               scan_ctrl.start = 1'b1;
               op_in    = req_kind;
               owner_in = req_payload.owner_id;
               pages_in = size_pages;
               ptr_in   = '0;
               res_in   = '0;
               priority if (req_kind == REQ_ALLOC && alloc_bad) begin
                  res_in.status = STAT_INVALID;
                  state_in      = ST_DONE;
               end else if (req_kind == REQ_READ) begin
                  if (req_payload.page_index >= NUM_PAGES) begin
                     res_in.status = STAT_INVALID;
                     state_in      = ST_DONE;
                  end else begin
                     ptr_in   = IDX_W'(req_payload.page_index);
                     state_in = ST_READ;
                  end
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            scan_ctrl.step = 1'b1;
            // free releases matching pages as the walk passes them
            if (op_ff == REQ_FREE && owner_match) begin
               wr_en = 1'b1;
            end
            if (is_last) begin
               state_in = ST_EVAL;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end
         ST_EVAL: begin
            state_in = ST_DONE;
            unique case (op_ff)
               REQ_ALLOC: begin
                  priority if (scan_flags.owner_hit) begin
                     res_in.status = STAT_INUSE;
                  end else if (!scan_flags.found ||
                               CMP_W'(chosen_length) < CMP_W'(pages_ff)) begin
                     res_in.status = STAT_NOSPACE;
                  end else begin
                     res_in.status     = STAT_OK;
                     res_in.start_page = 5'(chosen_start);
                     res_in.page_count = 6'(pages_ff);
                     ptr_in            = chosen_start;
                     remain_in         = pages_ff;
                     state_in          = ST_MARK;
                  end
               end
               REQ_FREE: begin
                  res_in.status     = (tally != '0) ? STAT_OK : STAT_NOTFOUND;
                  res_in.page_count = 6'(tally);
               end
               REQ_FRAG: begin
                  res_in.status         = STAT_OK;
                  res_in.fragment_count = 5'(tally);
               end
               default: begin
                  res_in.status = STAT_INVALID;
               end
            endcase
         end
         ST_MARK: begin
            wr_en   = 1'b1;
            wr_used = 1'b1;
            if (remain_ff == PAGES_W'(1)) begin
               state_in = ST_DONE;
            end else begin
               ptr_in    = ptr_ff + 1'b1;
               remain_in = remain_ff - 1'b1;
            end
         end
         ST_READ: begin
            res_in.status     = STAT_OK;
            res_in.read_used  = used_cur;
            res_in.read_owner = used_cur ? 8'(owner_cur) : 8'd0;
            state_in          = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register: holds a result until taken
   assign rsp_valid_in   = rsp_load || (rsp_valid_ff && rsp_stall);
   assign rsp_payload_in = rsp_load ? res_ff : rsp_payload_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         fit_mode_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         fit_mode_ff  <= fit_mode_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      owner_ff       <= owner_in;
      pages_ff       <= pages_in;
      remain_ff      <= remain_in;
      ptr_ff         <= ptr_in;
      res_ff         <= res_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // a granted run only ever covers free pages
   a_mark_free_page: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MARK |-> !used_cur)
      else $error("allocation marks a page already in use");

   // marking never runs past the end of the map
   a_mark_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MARK |-> (int'(ptr_ff) + int'(remain_ff)) <= NUM_PAGES)
      else $error("allocation runs past the last page");

   // a new result appears only out of the done state
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("result raised outside the done state");

   // the page walk ends only in evaluation
   a_scan_exit: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |=> state_ff == ST_SCAN || state_ff == ST_EVAL)
      else $error("page walk left without evaluation");

endmodule
